// ===== rtl/core/owr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owr_pkg
// shared widths, step counts and controller/datapath interface types
// ----------------------------------------------------------------------------
package owr_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 31;   // square of a 16-bit sample fits 31 bits
  localparam int HALF_SUM_W = 38;
  localparam int WIN_SUM_W  = HALF_SUM_W + 1;
  localparam int FRAC_SHIFT = 16;   // 8 fraction bits after the root
  localparam int WORK_W     = 56;   // root operand word, even
  localparam int ROOT_W     = WORK_W / 2;
  localparam int RMS_W      = 24;
  localparam int ACC_W      = 42;
  localparam int TOTAL_W    = 40;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = 5;

  typedef struct packed {
    logic accept;     // input item taken this cycle
    logic sqrt_step;  // one root bit
    logic finish;     // load window result into output register
  } owr_cmd_t;

  typedef struct packed {
    logic win;        // next accepted item completes a half window
    logic out_free;   // output register can take a result this cycle
  } owr_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/owr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owr_ctrl
// sequencer for item intake and square root steps
// ----------------------------------------------------------------------------
module owr_ctrl
  import owr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire owr_status_t status,
  output owr_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQRT = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] cnt_next;

  always_comb begin
    cmd        = '0;
    in_stall   = 1'b1;
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        in_stall   = !status.out_free;
        cmd.accept = in_valid && status.out_free;
        if (cmd.accept && status.win) begin
          state_next = ST_SQRT;
          cnt_next   = '0;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + STEP_W'(1);
        if (cnt == SQRT_LAST) begin
          state_next = ST_DONE;
          cnt_next   = '0;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input not stalled while busy");

  a_win_starts_root: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && status.win) |=> (state == ST_SQRT && cnt == '0))
    else $error("window item did not start the root");

  a_root_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) |-> (cnt <= SQRT_LAST))
    else $error("root step count out of range");

endmodule
`default_nettype wire

// ===== rtl/core/owr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owr_datapath
// half sums, bit-serial root scaled by the window length, accumulator,
// output register
// ----------------------------------------------------------------------------
module owr_datapath
  import owr_pkg::*;
#(
  parameter int WINDOW_LEN = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire owr_cmd_t                   cmd,
  output owr_status_t                     status,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       end_of_vector,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [RMS_W-1:0]                window_rms,
  output logic                            window_valid,
  output logic [TOTAL_W-1:0]              total_quarter,
  output logic                            total_valid
);

  localparam int HALF_LEN  = WINDOW_LEN / 2;
  localparam int CNT_W     = $clog2(HALF_LEN + 1);
  localparam int N_W       = $clog2(WINDOW_LEN + 1);
  localparam int NR_W      = ROOT_W + N_W;
  localparam int REM_W     = NR_W + 2;
  localparam logic [CNT_W-1:0]     HALF_CNT = CNT_W'(HALF_LEN);
  localparam logic [N_W-1:0]       WIN_N    = N_W'(WINDOW_LEN);
  localparam logic [HALF_SUM_W-1:0] HALF_MAX = '1;
  localparam logic [ACC_W-1:0]     ACC_MAX  = '1;
  localparam logic [RMS_W-1:0]     RMS_MAX  = '1;

  logic [HALF_SUM_W-1:0] prev_sum;
  logic [HALF_SUM_W-1:0] cur_sum;
  logic [CNT_W-1:0]      count;
  logic [ACC_W-1:0]      acc;
  logic [WORK_W-1:0]     work;
  logic [REM_W-1:0]      sq_rem;
  logic [ROOT_W-1:0]     root;
  logic [NR_W-1:0]       nroot;
  logic                  pend_last;

  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [HALF_SUM_W:0]          cur_add;
  logic [HALF_SUM_W-1:0]        cur_next;
  logic [CNT_W-1:0]             count_next;
  logic [WIN_SUM_W-1:0]         win_sum;
  logic [REM_W+1:0]             sq_sh;
  logic [REM_W+1:0]             sq_trial;
  logic                         sq_ge;
  logic [NR_W-1:0]              nroot_next;
  logic [RMS_W-1:0]             rms;
  logic [ACC_W:0]               acc_add;
  logic [ACC_W-1:0]             acc_next;
  logic                         out_take;

  // square and saturating half sum
  assign sq_full    = sample * sample;
  assign cur_add    = {1'b0, cur_sum} + (HALF_SUM_W + 1)'(sq_full[SQ_W-1:0]);
  assign cur_next   = cur_add[HALF_SUM_W] ? HALF_MAX : cur_add[HALF_SUM_W-1:0];
  assign count_next = count + CNT_W'(1);
  assign win_sum    = WIN_SUM_W'(prev_sum) + WIN_SUM_W'(cur_next);

  // digit-by-digit root of work / WINDOW_LEN, two operand bits a step;
  // nroot holds WINDOW_LEN * root, so the trial term carries the division
  assign sq_sh      = {sq_rem, work[WORK_W-1 -: 2]};
  assign sq_trial   = (REM_W + 2)'({nroot, 2'b00}) + (REM_W + 2)'(WIN_N);
  assign sq_ge      = sq_sh >= sq_trial;
  assign nroot_next = {nroot[NR_W-2:0], 1'b0} + (sq_ge ? NR_W'(WIN_N) : NR_W'(0));

  assign rms      = (root[ROOT_W-1:RMS_W] != '0) ? RMS_MAX : root[RMS_W-1:0];
  assign acc_add  = {1'b0, acc} + (ACC_W + 1)'(rms);
  assign acc_next = acc_add[ACC_W] ? ACC_MAX : acc_add[ACC_W-1:0];

  assign out_take        = out_valid && !out_stall;
  assign status.out_free = !out_valid || !out_stall;
  assign status.win      = count_next >= HALF_CNT;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sum  <= '0;
      cur_sum   <= '0;
      count     <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
      pend_last <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept) begin
        if (status.win) begin
          prev_sum  <= cur_next;
          cur_sum   <= '0;
          count     <= '0;
          pend_last <= end_of_vector;
        end else if (end_of_vector) begin
          cur_sum   <= '0;
          count     <= '0;
          acc       <= '0;
          out_valid <= 1'b1;
        end else begin
          cur_sum <= cur_next;
          count   <= count_next;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        acc       <= pend_last ? '0 : acc_next;
      end
    end
  end

  // arithmetic and output payload
  always_ff @(posedge clk) begin
    if (cmd.accept && status.win) begin
      work   <= WORK_W'({win_sum, {FRAC_SHIFT{1'b0}}});
      sq_rem <= '0;
      root   <= '0;
      nroot  <= '0;
    end else if (cmd.sqrt_step) begin
      sq_rem <= sq_ge ? REM_W'(sq_sh - sq_trial) : sq_sh[REM_W-1:0];
      root   <= {root[ROOT_W-2:0], sq_ge};
      nroot  <= nroot_next;
      work   <= {work[WORK_W-3:0], 2'b00};
    end
    if (cmd.accept && !status.win && end_of_vector) begin
      window_rms    <= '0;
      window_valid  <= 1'b0;
      total_quarter <= acc[ACC_W-1:2];
      total_valid   <= 1'b1;
    end else if (cmd.finish) begin
      window_rms    <= rms;
      window_valid  <= 1'b1;
      total_quarter <= pend_last ? acc_next[ACC_W-1:2] : '0;
      total_valid   <= pend_last;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count < HALF_CNT)
    else $error("half sample count reached half length");

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_valid || total_valid))
    else $error("result item carries neither window nor total");

  a_no_load_collision: assert property (@(posedge clk) disable iff (rst)
    !(cmd.finish && cmd.accept))
    else $error("finish and accept in the same cycle");

endmodule
`default_nettype wire

// ===== rtl/core/overlapped_window_rms_accumulator.sv =====
// an end-of-vector item that closes no half window gives its result in the next cycle
// an item closing a half window gives its result after 28 root steps and the done state,
// which waits for a free output register; throughput: 1 item per cycle within a half while
// the output register is free; the bit-serial root and done state stall the input meanwhile
// reset (rst, synchronous): half sums, count and accumulator cleared, output empty
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overlapped_window_rms_accumulator
// 50% overlap window rms of a sample stream, summed per vector and reported
// as a quarter of the sum on end of vector
// ----------------------------------------------------------------------------
module overlapped_window_rms_accumulator
  import owr_pkg::*;
#(
  parameter int WINDOW_LEN = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // sample item channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       end_of_vector,
  // result item channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [RMS_W-1:0]                window_rms,
  output logic                            window_valid,
  output logic [TOTAL_W-1:0]              total_quarter,
  output logic                            total_valid
);

  // command and status between sequencer and datapath
  owr_cmd_t    cmd;
  owr_status_t status;

  // sequencer: takes items, then walks the root steps
  // after each completed half window
  owr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: squares into the current half, forms (prev + cur) << 16,
  // takes the root of that over the window length one root bit a cycle,
  // with the window length folded into the trial term, then saturates,
  // accumulates and loads the output register
  owr_datapath #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample        (sample),
    .end_of_vector (end_of_vector),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .window_rms    (window_rms),
    .window_valid  (window_valid),
    .total_quarter (total_quarter),
    .total_valid   (total_valid)
  );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the half-overlap window rms accumulator: sample
// items go in with random gaps, result items come out under random stall,
// and each result is matched field by field against an in-bench prediction
// ----------------------------------------------------------------------------
module tb;
  import owr_pkg::*;

  localparam int WINDOW_LEN     = 256;
  localparam int HALF_LEN       = WINDOW_LEN / 2;
  localparam int WINDOW_LATENCY = 30;    // sizes the quiet spell at the end of the run
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving either way
  localparam int MIN_ITEMS      = 2000;

  // one expected result item
  typedef struct packed {
    logic [RMS_W-1:0]   window_rms;
    logic               window_valid;
    logic [TOTAL_W-1:0] total_quarter;
    logic               total_valid;
  } rms_result_t;

  // running prediction of the block and the queue of results still owed
  class rms_ledger;
    int unsigned       window_len;
    int unsigned       half_len;
    logic [63:0]       prev_half;
    logic [63:0]       cur_half;
    int unsigned       half_count;
    logic [63:0]       rms_sum;
    rms_result_t       due_results[$];

    function new(int unsigned wlen);
      window_len = wlen;
      half_len   = wlen >> 1;
      prev_half  = '0;
      cur_half   = '0;
      half_count = 0;
      rms_sum    = '0;
    endfunction

    // floor square root, two bits of the operand per pass
    function logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] probe;
      logic [63:0] rest;
      root  = '0;
      rest  = v;
      probe = 64'd1 << 62;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
        if (rest >= root + probe) begin
          rest = rest - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root;
    endfunction

    // an accepted sample item: update the state, queue any result it causes
    function void take_sample(logic signed [SAMPLE_W-1:0] s, logic last);
      logic [63:0] half_max;
      logic [63:0] acc_max;
      logic [63:0] rms_max;
      logic [63:0] sq;
      logic [63:0] win_total;
      logic [63:0] scaled;
      logic [63:0] root;
      logic [63:0] quarter;
      longint      sv;
      bit          win;
      rms_result_t r;
      half_max = (64'd1 << HALF_SUM_W) - 64'd1;
      acc_max  = (64'd1 << ACC_W) - 64'd1;
      rms_max  = (64'd1 << RMS_W) - 64'd1;
      sv = s;
      sq = 64'(sv * sv);
      win  = 1'b0;
      root = '0;

      cur_half = cur_half + sq;
      if (cur_half > half_max) cur_half = half_max;
      half_count++;

      if (half_count >= half_len) begin
        win_total = prev_half + cur_half;
        scaled    = (win_total << FRAC_SHIFT) / 64'(window_len);
        root      = floor_root(scaled);
        if (root > rms_max) root = rms_max;
        rms_sum = rms_sum + root;
        if (rms_sum > acc_max) rms_sum = acc_max;
        prev_half  = cur_half;
        cur_half   = '0;
        half_count = 0;
        win        = 1'b1;
      end

      if (!win && !last) return;

      r.window_rms   = win ? root[RMS_W-1:0] : '0;
      r.window_valid = win;
      if (last) begin
        quarter         = rms_sum >> 2;
        r.total_quarter = quarter[TOTAL_W-1:0];
        r.total_valid   = 1'b1;
        // trailing partial half is dropped, previous half kept
        rms_sum    = '0;
        cur_half   = '0;
        half_count = 0;
      end else begin
        r.total_quarter = '0;
        r.total_valid   = 1'b0;
      end
      due_results.push_back(r);
    endfunction

    // compare a result item with the oldest one owed; empty string on a match
    function string match_result(rms_result_t got);
      rms_result_t want;
      string       msg;
      if (due_results.size() == 0)
        return $sformatf("result with none owed: rms %h/%b total %h/%b",
                         got.window_rms, got.window_valid,
                         got.total_quarter, got.total_valid);
      want = due_results.pop_front();
      msg  = "";
      if (got.window_rms !== want.window_rms)
        msg = {msg, $sformatf(" window_rms %h want %h", got.window_rms, want.window_rms)};
      if (got.window_valid !== want.window_valid)
        msg = {msg, $sformatf(" window_valid %b want %b", got.window_valid,
                              want.window_valid)};
      if (got.total_quarter !== want.total_quarter)
        msg = {msg, $sformatf(" total_quarter %h want %h", got.total_quarter,
                              want.total_quarter)};
      if (got.total_valid !== want.total_valid)
        msg = {msg, $sformatf(" total_valid %b want %b", got.total_valid,
                              want.total_valid)};
      return msg;
    endfunction

    function int owed();
      return due_results.size();
    endfunction
  endclass

  // block pins; the inputs driven here are known from time zero
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       end_of_vector = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [RMS_W-1:0]           window_rms;
  logic                       window_valid;
  logic [TOTAL_W-1:0]         total_quarter;
  logic                       total_valid;

  rms_ledger board;
  int        mismatches   = 0;
  int        results_seen = 0;
  int        quiet_cycles = 0;
  int        items_sent   = 0;
  bit        calm         = 1'b0;   // set for stretches with no idling on either side

  overlapped_window_rms_accumulator #(
    .WINDOW_LEN(WINDOW_LEN)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .end_of_vector(end_of_vector),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .window_rms   (window_rms),
    .window_valid (window_valid),
    .total_quarter(total_quarter),
    .total_valid  (total_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    mismatches++;
    $display("mismatch at result %0d:%s", results_seen, msg);
  endtask

  // idle cycles before an item, or stall cycles on a result
  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: everything sampled at the rising edge, before the block updates
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    string       msg;
    rms_result_t got;
    if (!rst) begin
      quiet_cycles = quiet_cycles + 1;
      if (in_valid && !in_stall) begin
        board.take_sample(sample, end_of_vector);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        got.window_rms    = window_rms;
        got.window_valid  = window_valid;
        got.total_quarter = total_quarter;
        got.total_valid   = total_valid;
        msg = board.match_result(got);
        results_seen = results_seen + 1;
        quiet_cycles = 0;
        if (msg != "") report(msg);
      end
    end
  end

  // watchdog: too long with nothing moving ends the run
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: a fresh stall count after every result, spent only while a
  // result is on offer so that the stall really lands on it
  // ---------------------------------------------------------------------------
  int rx_seen = 0;
  int rx_wait = 0;

  always @(negedge clk) begin
    if (results_seen != rx_seen) begin
      rx_seen = results_seen;
      rx_wait = idle_draw();
    end
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      if (out_valid === 1'b1) rx_wait = rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // sender: entered and left at a falling edge; valid stays high between
  // back-to-back items and is only lowered for a gap
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic signed [SAMPLE_W-1:0] s, input logic last);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    sample        <= s;
    end_of_vector <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    @(negedge clk);
  endtask

  // hold off the sender until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.owed() != 0) @(negedge clk);
  endtask

  // sample content for one vector
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int mode);
    logic [31:0] r;
    r = $urandom();
    case (mode)
      0: return r[SAMPLE_W-1:0];
      1: return r[0] ? 16'sh8000 : 16'sh7fff;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      default: begin
        if (r[31:29] == 3'd0) return r[0] ? 16'sh8000 : 16'sh7fff;
        return r[SAMPLE_W-1:0];
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int   kind;
    int   len;
    int   mode;
    int   vectors;
    logic last;
    board = new(WINDOW_LEN);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // end of vector on the very first item: nothing accumulated
    send_item(16'sh0000, 1'b1);
    // extremes, then an end that drops the partial half
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7fff, 1'b0);
    send_item(16'shffff, 1'b0);
    send_item(16'sh0001, 1'b0);
    send_item(16'sh4000, 1'b0);
    send_item(16'sh8000, 1'b1);
    // back-to-back ends with no window
    send_item(16'sh7fff, 1'b1);
    send_item(16'sh8000, 1'b1);
    send_item(16'sh5555, 1'b0);
    send_item(16'shaaaa, 1'b0);
    send_item(16'sh0000, 1'b1);
    drain_results();

    // random vectors, mostly whole halves with random content
    vectors = 0;
    while (items_sent < MIN_ITEMS) begin
      kind = $urandom_range(0, 9);
      mode = $urandom_range(0, 3);
      calm = ($urandom_range(0, 3) == 0);
      if (kind <= 5) begin
        // no tail puts the end on the item that closes a window
        len = $urandom_range(1, 3) * HALF_LEN;
        if ($urandom_range(0, 1)) len = len + $urandom_range(1, HALF_LEN - 1);
      end else if (kind <= 7) begin
        len = $urandom_range(1, 8);
      end else begin
        len = $urandom_range(1, 3 * HALF_LEN);
      end
      for (int i = 0; i < len; i++) begin
        if (kind >= 8) last = ($urandom_range(0, 63) == 0);
        else last = (i == len - 1);
        send_item(pick_sample(mode), last);
      end
      vectors++;
      if (vectors % 8 == 0) drain_results();
    end

    // wind down: everything back, then a quiet spell for stray results
    calm = 1'b0;
    drain_results();
    repeat (2 * WINDOW_LATENCY) @(posedge clk);
    if (mismatches == 0 && board.owed() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/owr_pkg.sv
rtl/core/owr_ctrl.sv
rtl/core/owr_datapath.sv
rtl/core/overlapped_window_rms_accumulator.sv
sim/tb.sv
